[hw/rtl/sbic_pkg.sv]
// Shared types, opcode numbers, status codes and decode helpers of the
// stack bytecode integer core. No dependencies.
`default_nettype none
package sbic_pkg;

    typedef enum logic [3:0] {
        K_NOP, K_CONST, K_BIPUSH, K_LOAD, K_STORE, K_POP, K_DUP,
        K_ARITH, K_IINC, K_IF, K_IFCMP, K_GOTO, K_RETURN, K_BAD
    } t_kind;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_RETURNED    = 3'd1;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW    = 3'd4;

    localparam logic [7:0] OP_NOP       = 8'd0;
    localparam logic [7:0] OP_ICONST_M1 = 8'd2;
    localparam logic [7:0] OP_ICONST_0  = 8'd3;
    localparam logic [7:0] OP_ICONST_5  = 8'd8;
    localparam logic [7:0] OP_BIPUSH    = 8'd16;
    localparam logic [7:0] OP_ILOAD     = 8'd21;
    localparam logic [7:0] OP_ILOAD_0   = 8'd26;
    localparam logic [7:0] OP_ILOAD_3   = 8'd29;
    localparam logic [7:0] OP_FLOAD_0   = 8'd34;
    localparam logic [7:0] OP_FLOAD_3   = 8'd37;
    localparam logic [7:0] OP_ALOAD_0   = 8'd42;
    localparam logic [7:0] OP_ALOAD_3   = 8'd45;
    localparam logic [7:0] OP_ISTORE    = 8'd54;
    localparam logic [7:0] OP_ISTORE_0  = 8'd59;
    localparam logic [7:0] OP_ISTORE_3  = 8'd62;
    localparam logic [7:0] OP_FSTORE_0  = 8'd67;
    localparam logic [7:0] OP_FSTORE_3  = 8'd70;
    localparam logic [7:0] OP_ASTORE_0  = 8'd75;
    localparam logic [7:0] OP_ASTORE_3  = 8'd78;
    localparam logic [7:0] OP_POP       = 8'd87;
    localparam logic [7:0] OP_DUP       = 8'd89;
    localparam logic [7:0] OP_IADD      = 8'd96;
    localparam logic [7:0] OP_ISUB      = 8'd100;
    localparam logic [7:0] OP_IMUL      = 8'd104;
    localparam logic [7:0] OP_IINC      = 8'd132;
    localparam logic [7:0] OP_IFEQ      = 8'd153;
    localparam logic [7:0] OP_IFNE      = 8'd154;
    localparam logic [7:0] OP_IFLE      = 8'd158;
    localparam logic [7:0] OP_IF_ICMPEQ = 8'd159;
    localparam logic [7:0] OP_IF_ICMPLT = 8'd161;
    localparam logic [7:0] OP_IF_ICMPLE = 8'd164;
    localparam logic [7:0] OP_GOTO      = 8'd167;
    localparam logic [7:0] OP_RETURN    = 8'd177;

    localparam logic [2:0] C_EQ = 3'd0;
    localparam logic [2:0] C_NE = 3'd1;
    localparam logic [2:0] C_LT = 3'd2;
    localparam logic [2:0] C_GE = 3'd3;
    localparam logic [2:0] C_GT = 3'd4;

    function automatic logic in_rng(input logic [7:0] op, input logic [7:0] lo,
                                    input logic [7:0] hi);
        return (op >= lo) && (op <= hi);
    endfunction

    function automatic t_kind kind_of(input logic [7:0] op);
        t_kind k;
        k = K_BAD;
        if (op == OP_NOP) k = K_NOP;
        else if (in_rng(op, OP_ICONST_M1, OP_ICONST_5)) k = K_CONST;
        else if (op == OP_BIPUSH) k = K_BIPUSH;
        else if (op == OP_ILOAD || in_rng(op, OP_ILOAD_0, OP_ILOAD_3) ||
                 in_rng(op, OP_FLOAD_0, OP_FLOAD_3) ||
                 in_rng(op, OP_ALOAD_0, OP_ALOAD_3)) k = K_LOAD;
        else if (op == OP_ISTORE || in_rng(op, OP_ISTORE_0, OP_ISTORE_3) ||
                 in_rng(op, OP_FSTORE_0, OP_FSTORE_3) ||
                 in_rng(op, OP_ASTORE_0, OP_ASTORE_3)) k = K_STORE;
        else if (op == OP_POP) k = K_POP;
        else if (op == OP_DUP) k = K_DUP;
        else if (op == OP_IADD || op == OP_ISUB || op == OP_IMUL) k = K_ARITH;
        else if (op == OP_IINC) k = K_IINC;
        else if (in_rng(op, OP_IFEQ, OP_IFLE)) k = K_IF;
        else if (in_rng(op, OP_IF_ICMPEQ, OP_IF_ICMPLE)) k = K_IFCMP;
        else if (op == OP_GOTO) k = K_GOTO;
        else if (op == OP_RETURN) k = K_RETURN;
        return k;
    endfunction

    function automatic logic rel_holds(input logic signed [31:0] a,
                                       input logic signed [31:0] b,
                                       input logic [2:0] cond);
        logic r;
        case (cond)
            C_EQ: r = (a == b);
            C_NE: r = (a != b);
            C_LT: r = (a < b);
            C_GE: r = (a >= b);
            C_GT: r = (a > b);
            default: r = (a <= b);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/sbic_if.sv]
// Request and response channel interfaces of the stack bytecode core.
// Valid/ready handshake; no package dependency.
`default_nettype none
interface sbic_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] opcode;
    logic [7:0] operand_hi;
    logic [7:0] operand_lo;
    modport source (output valid, output opcode, output operand_hi, output operand_lo,
                    input ready);
    modport sink (input valid, input opcode, input operand_hi, input operand_lo,
                  output ready);
endinterface

interface sbic_out_if #(parameter int DEPTH_W = 7);
    logic               valid;
    logic               ready;
    logic [15:0]        next_pc;
    logic signed [31:0] top_value;
    logic [DEPTH_W-1:0] depth;
    logic [2:0]         status;
    modport source (output valid, output next_pc, output top_value, output depth,
                    output status, input ready);
    modport sink (input valid, input next_pc, input top_value, input depth,
                  input status, output ready);
endinterface
`default_nettype wire

[hw/rtl/stack_bytecode_integer_core_unit.sv]
// Top level of the stack bytecode integer core: decode, execute and state.
// Uses sbic_pkg, sbic_if, sbic_stack_mem and sbic_locals.
//
// One bytecode is taken per request and answered by one response, at one per
// cycle sustained while o_rsp is ready; requests register in execute, results
// in output registers. The top two stack entries and pc are registers; deeper
// entries and local slots are memories read ahead, so execute sets the rate.
// Local slots read as zero after reset with no clearing pass.
`default_nettype none
module stack_bytecode_integer_core_unit #(
    parameter int STACK_DEPTH = 64,
    parameter int LOCAL_COUNT = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sbic_in_if.sink   i_req,
    sbic_out_if.source o_rsp
);
    import sbic_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int LAW = $clog2(LOCAL_COUNT);

    logic [LAW-1:0] lut [256];
    for (genvar g = 0; g < 256; g++) begin : g_lut
        assign lut[g] = LAW'(g % LOCAL_COUNT);
    end

    function automatic logic [LAW-1:0] loc_idx(input logic [7:0] op, input logic [7:0] hi);
        logic [LAW-1:0] r;
        if (op == OP_ILOAD || op == OP_ISTORE || op == OP_IINC) r = lut[hi];
        else if (op < OP_ISTORE) r = LAW'(2'(op[1:0] + 2'd2));
        else r = LAW'(2'(op[1:0] + 2'd1));
        return r;
    endfunction

    logic           r_s1_valid;
    logic [7:0]     r_op, r_hi, r_lo;
    logic [15:0]    r_pc;
    logic [SPW-1:0] r_sp;
    logic [31:0]    r_tos, r_nos;
    logic           r_o_valid;
    logic [15:0]    r_o_pc;
    logic [31:0]    r_o_top;
    logic [SPW-1:0] r_o_depth;
    logic [2:0]     r_o_status;

    logic           s1_fire, s1_hold;
    t_kind          kind;
    logic [1:0]     pops, pushes;
    logic [2:0]     status;
    logic           ok, taken;
    logic [15:0]    offset, n_pc;
    logic [SPW-1:0] n_sp, sp_after;
    logic [31:0]    n_tos, n_nos, push_val, arith, m0, m1, lv;
    logic           st_we, lc_we;
    logic [31:0]    lc_wdata;
    logic [SPW:0]   need;

    assign s1_fire = r_s1_valid && (!r_o_valid || o_rsp.ready);
    assign s1_hold = r_s1_valid && !s1_fire;
    assign i_req.ready = !r_s1_valid || s1_fire;

    always_comb begin
        kind   = kind_of(r_op);
        pops   = 2'd0;
        pushes = 2'd0;
        status = ST_OK;
        case (kind)
            K_CONST, K_BIPUSH, K_LOAD: pushes = 2'd1;
            K_STORE, K_POP, K_IF: pops = 2'd1;
            K_DUP: begin
                pops   = 2'd1;
                pushes = 2'd2;
            end
            K_ARITH: begin
                pops   = 2'd2;
                pushes = 2'd1;
            end
            K_IFCMP: pops = 2'd2;
            K_RETURN: status = ST_RETURNED;
            K_BAD: status = ST_UNSUPPORTED;
            default: ;
        endcase
        need = (SPW+1)'(r_sp) - (SPW+1)'(pops) + (SPW+1)'(pushes);
        if (status == ST_OK) begin
            if (r_sp < SPW'(pops)) status = ST_UNDERFLOW;
            else if (need > (SPW+1)'(STACK_DEPTH)) status = ST_OVERFLOW;
        end
        ok     = (status == ST_OK);
        offset = {r_hi, r_lo};

        case (r_op)
            OP_IADD: arith = r_nos + r_tos;
            OP_ISUB: arith = r_nos - r_tos;
            default: arith = r_nos * r_tos;
        endcase
        case (kind)
            K_CONST: push_val = {24'd0, r_op} - 32'd3;
            K_BIPUSH: push_val = {{24{r_hi[7]}}, r_hi};
            K_LOAD: push_val = lv;
            default: push_val = r_tos;
        endcase

        taken = 1'b0;
        if (kind == K_IF) taken = rel_holds(r_tos, 32'sd0, 3'(r_op - OP_IFEQ));
        if (kind == K_IFCMP) taken = rel_holds(r_nos, r_tos, 3'(r_op - OP_IF_ICMPEQ));

        n_tos = r_tos;
        n_nos = r_nos;
        n_sp  = r_sp;
        n_pc  = r_pc;
        if (ok) begin
            case (kind)
                K_CONST, K_BIPUSH, K_LOAD, K_DUP: begin
                    n_nos = r_tos;
                    n_tos = push_val;
                    n_sp  = r_sp + SPW'(1);
                end
                K_STORE, K_POP, K_IF: begin
                    n_tos = r_nos;
                    n_nos = m0;
                    n_sp  = r_sp - SPW'(1);
                end
                K_ARITH: begin
                    n_tos = arith;
                    n_nos = m0;
                    n_sp  = r_sp - SPW'(1);
                end
                K_IFCMP: begin
                    n_tos = m0;
                    n_nos = m1;
                    n_sp  = r_sp - SPW'(2);
                end
                default: ;
            endcase
            case (kind)
                K_BIPUSH: n_pc = r_pc + 16'd2;
                K_LOAD, K_STORE: n_pc = r_pc +
                    ((r_op == OP_ILOAD || r_op == OP_ISTORE) ? 16'd2 : 16'd1);
                K_IINC: n_pc = r_pc + 16'd3;
                K_IF, K_IFCMP: n_pc = r_pc + (taken ? offset : 16'd3);
                K_GOTO: n_pc = r_pc + offset;
                default: n_pc = r_pc + 16'd1;
            endcase
        end

        st_we = s1_fire && ok && (pushes != 2'd0) && (r_sp >= SPW'(2));
        lc_we = s1_fire && ok && (kind == K_STORE || kind == K_IINC);
        lc_wdata = (kind == K_STORE) ? r_tos : lv + {{24{r_lo[7]}}, r_lo};
        sp_after = s1_fire ? n_sp : r_sp;
    end

    sbic_stack_mem #(.DEPTH(STACK_DEPTH), .AW(SAW)) u_stack (
        .i_clk    (i_clk),
        .i_we     (st_we),
        .i_waddr  (SAW'(r_sp - SPW'(2))),
        .i_wdata  (r_nos),
        .i_raddr0 (SAW'(sp_after - SPW'(3))),
        .i_raddr1 (SAW'(sp_after - SPW'(4))),
        .o_rdata0 (m0),
        .o_rdata1 (m1)
    );

    sbic_locals #(.COUNT(LOCAL_COUNT), .AW(LAW)) u_locals (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (lc_we),
        .i_waddr (loc_idx(r_op, r_hi)),
        .i_wdata (lc_wdata),
        .i_raddr (s1_hold ? loc_idx(r_op, r_hi) : loc_idx(i_req.opcode, i_req.operand_hi)),
        .o_rdata (lv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_pc       <= '0;
            r_sp       <= '0;
        end else begin
            if (i_req.ready) r_s1_valid <= i_req.valid;
            if (s1_fire) r_o_valid <= 1'b1;
            else if (o_rsp.ready) r_o_valid <= 1'b0;
            if (s1_fire) begin
                r_pc <= n_pc;
                r_sp <= n_sp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready) begin
            r_op <= i_req.opcode;
            r_hi <= i_req.operand_hi;
            r_lo <= i_req.operand_lo;
        end
        if (s1_fire) begin
            r_tos      <= n_tos;
            r_nos      <= n_nos;
            r_o_pc     <= n_pc;
            r_o_top    <= (n_sp != '0) ? n_tos : 32'd0;
            r_o_depth  <= n_sp;
            r_o_status <= status;
        end
    end

    assign o_rsp.valid     = r_o_valid;
    assign o_rsp.next_pc   = r_o_pc;
    assign o_rsp.top_value = r_o_top;
    assign o_rsp.depth     = r_o_depth;
    assign o_rsp.status    = r_o_status;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");
    a_err_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && !ok |=> r_sp == $past(r_sp) && r_pc == $past(r_pc))
        else $error("faulting instruction changed state");
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> i_req.ready)
        else $error("empty execute stage refused a request");
    a_depth_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> o_rsp.valid && o_rsp.depth == r_sp)
        else $error("response depth differs from stack pointer");
`endif
endmodule
`default_nettype wire

[hw/rtl/sbic_stack_mem.sv]
// Operand stack memory below the two cached top entries, with two read ports.
// A read of the entry written at the same edge returns the new data.
`default_nettype none
module sbic_stack_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr0,
    input  wire logic [AW-1:0] i_raddr1,
    output logic [31:0]        o_rdata0,
    output logic [31:0]        o_rdata1
);
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_q0, r_q1, r_fwd;
    logic        r_hit0, r_hit1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q0   <= r_mem[i_raddr0];
        r_q1   <= r_mem[i_raddr1];
        r_fwd  <= i_wdata;
        r_hit0 <= i_we && (i_waddr == i_raddr0);
        r_hit1 <= i_we && (i_waddr == i_raddr1);
    end

    assign o_rdata0 = r_hit0 ? r_fwd : r_q0;
    assign o_rdata1 = r_hit1 ? r_fwd : r_q1;
endmodule
`default_nettype wire

[hw/rtl/sbic_locals.sv]
// Local slot memory with per-entry valid bits that make unwritten slots read zero.
// A read of the slot written at the same edge returns the new data.
`default_nettype none
module sbic_locals #(
    parameter int COUNT = 256,
    parameter int AW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [31:0]        o_rdata
);
    logic [31:0]    r_mem [COUNT];
    logic [COUNT-1:0] r_valid;
    logic [31:0]    r_q, r_fwd;
    logic           r_vq, r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q   <= r_mem[i_raddr];
        r_vq  <= r_valid[i_raddr] && i_rst_n;
        r_fwd <= i_wdata;
        r_hit <= i_we && i_rst_n && (i_waddr == i_raddr);
    end

    assign o_rdata = r_hit ? r_fwd : (r_vq ? r_q : 32'd0);
endmodule
`default_nettype wire
